### hdl/i2cblm_pkg.sv
// Package for the bit-level I2C master: operation codes, item field widths,
// the pin state record, and the per-phase pin sequences.
// No dependencies.
package i2cblm_pkg;

    localparam int KIND_W       = 3;
    localparam int BYTE_W       = 8;
    localparam int TICKS_W      = 10;
    localparam int PHASE_W      = 5;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;
    localparam int WRITE_PHASES = 25;
    localparam int READ_PHASES  = 18;
    localparam int BIT_PHASES   = 4;
    localparam int READ_BITS_PH = 16;

    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    typedef enum logic [4:0] {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_STOP  = 5'b00100,
        OP_WRITE = 5'b01000,
        OP_READ  = 5'b10000
    } op_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              in_mode;
        logic [BYTE_W-1:0] shift;
    } pins_t;

    localparam pins_t PINS_RESET = '{scl: 1'b1, sda: 1'b1, in_mode: 1'b0, shift: '0};

    function automatic op_t kind_to_op(input logic [KIND_W-1:0] kind);
        op_t op;
        unique case (kind)
            KIND_START: op = OP_START;
            KIND_STOP:  op = OP_STOP;
            KIND_WRITE: op = OP_WRITE;
            KIND_READ:  op = OP_READ;
            default:    op = OP_IDLE;
        endcase
        return op;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_count(input op_t op);
        logic [PHASE_W-1:0] n;
        unique case (op)
            OP_START, OP_STOP: n = PHASE_W'(BIT_PHASES);
            OP_WRITE:          n = PHASE_W'(WRITE_PHASES);
            OP_READ:           n = PHASE_W'(READ_PHASES);
            default:           n = '0;
        endcase
        return n;
    endfunction

    // Applies the pin changes made on the first tick of a phase. For writes,
    // sub is the position within the three-phase bit slot.
    function automatic pins_t enter_phase(input op_t op, input logic [PHASE_W-1:0] ph,
                                          input logic [1:0] sub, input logic sda_now,
                                          input logic ack, input pins_t cur);
        pins_t p;
        p = cur;
        unique case (op)
            OP_START: begin
                case (ph[1:0])
                    2'd0:    p.sda = 1'b1;
                    2'd1:    p.scl = 1'b1;
                    2'd2:    p.sda = 1'b0;
                    default: p.scl = 1'b0;
                endcase
            end
            OP_STOP: begin
                case (ph[1:0])
                    2'd0:    p.sda = 1'b0;
                    2'd1:    p.scl = 1'b1;
                    2'd2:    p.sda = 1'b1;
                    default: p.scl = 1'b0;
                endcase
            end
            OP_WRITE: begin
                if (ph < PHASE_W'(WRITE_PHASES - 1)) begin
                    case (sub)
                        2'd0: begin
                            p.scl = 1'b0;
                            p.sda = cur.shift[BYTE_W-1];
                        end
                        2'd1:    p.scl = 1'b1;
                        default: begin
                            p.scl   = 1'b0;
                            p.shift = {cur.shift[BYTE_W-2:0], 1'b0};
                        end
                    endcase
                end else begin
                    p.in_mode = 1'b1;
                    p.scl     = 1'b1;
                end
            end
            OP_READ: begin
                if (ph < PHASE_W'(READ_BITS_PH)) begin
                    if (!ph[0]) begin
                        p.in_mode = 1'b1;
                        p.scl     = 1'b1;
                        p.shift   = {cur.shift[BYTE_W-2:0], sda_now};
                    end else begin
                        p.scl = 1'b0;
                    end
                end else if (ph == PHASE_W'(READ_BITS_PH)) begin
                    p.in_mode = 1'b0;
                    p.sda     = ~ack;
                end else begin
                    p.scl = 1'b1;
                end
            end
            default: p = cur;
        endcase
        return p;
    endfunction

endpackage

### hdl/i2c_bit_level_master.sv
// Top level of the bit-level I2C master sequencer.
// Depends on i2cblm_pkg for codes, the pin record and the phase sequences.
//
// Each item on the input stream is one timebase tick and may carry a start,
// stop, write-byte or read-byte command. Its result item appears in the output
// register on the next clock. A new item is taken in any cycle in which that
// register is empty or its result is being taken, so items can follow with no
// gap, and a stalled result stream holds the input. The single registered
// next-state stage for the phase sequencer sets that rate of one item per clock.
module i2c_bit_level_master (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cblm_pkg::TICKS_W-1:0]     cfg_data,   // phase_ticks
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2cblm_pkg::S_TDATA_W-1:0]   s_tdata,    // tx_byte, send_ack, sda_in
    input  logic [i2cblm_pkg::KIND_W-1:0]      s_tuser,    // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scl_level, sda_release, busy_res, rx_valid, rx_byte, cmd_dropped
    output logic [i2cblm_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [i2cblm_pkg::TICKS_W-1:0] phase_ticks_reg;
    logic [i2cblm_pkg::TICKS_W-1:0] div_reg, div_next;
    logic [i2cblm_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]                     sub_reg, sub_next;
    i2cblm_pkg::op_t                op_reg, op_next;
    i2cblm_pkg::pins_t              pins_reg, pins_next;
    logic                           ack_reg, ack_next;
    logic [i2cblm_pkg::BYTE_W-1:0]  rx_hold_reg, rx_hold_next;
    logic                           m_tvalid_reg;
    logic [i2cblm_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [i2cblm_pkg::TICKS_W-1:0] period;
    logic [i2cblm_pkg::PHASE_W-1:0] ph_inc;
    logic [1:0]                     sub_inc;
    i2cblm_pkg::op_t                cmd_op;
    logic                           rx_valid;
    logic                           dropped;
    logic                           s_accept;

    logic [i2cblm_pkg::BYTE_W-1:0]  tx_byte;
    logic                           send_ack;
    logic                           sda_in;

    assign tx_byte  = s_tdata[i2cblm_pkg::BYTE_W-1:0];
    assign send_ack = s_tdata[i2cblm_pkg::BYTE_W];
    assign sda_in   = s_tdata[i2cblm_pkg::BYTE_W+1];

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        period       = (phase_ticks_reg == '0) ? i2cblm_pkg::TICKS_W'(1) : phase_ticks_reg;
        op_next      = op_reg;
        phase_next   = phase_reg;
        sub_next     = sub_reg;
        div_next     = div_reg;
        pins_next    = pins_reg;
        ack_next     = ack_reg;
        rx_hold_next = rx_hold_reg;
        rx_valid     = 1'b0;
        dropped      = 1'b0;
        ph_inc       = phase_reg + 1'b1;
        sub_inc      = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
        cmd_op       = i2cblm_pkg::kind_to_op(s_tuser);

        if (op_reg != i2cblm_pkg::OP_IDLE) begin
            if (div_reg >= period) begin
                if (ph_inc >= i2cblm_pkg::phase_count(op_reg)) begin
                    if (op_reg == i2cblm_pkg::OP_WRITE) begin
                        pins_next.scl     = 1'b0;
                        pins_next.in_mode = 1'b0;
                    end else if (op_reg == i2cblm_pkg::OP_READ) begin
                        pins_next.scl = 1'b0;
                        rx_hold_next  = pins_reg.shift;
                        rx_valid      = 1'b1;
                    end
                    op_next    = i2cblm_pkg::OP_IDLE;
                    phase_next = '0;
                    sub_next   = '0;
                    div_next   = '0;
                end else begin
                    pins_next  = i2cblm_pkg::enter_phase(op_reg, ph_inc, sub_inc, sda_in,
                                                         ack_reg, pins_reg);
                    phase_next = ph_inc;
                    sub_next   = sub_inc;
                    div_next   = i2cblm_pkg::TICKS_W'(1);
                end
            end else begin
                div_next = div_reg + 1'b1;
            end
        end

        if (cmd_op != i2cblm_pkg::OP_IDLE) begin
            if (op_next == i2cblm_pkg::OP_IDLE) begin
                op_next    = cmd_op;
                phase_next = '0;
                sub_next   = '0;
                div_next   = i2cblm_pkg::TICKS_W'(1);
                if (cmd_op == i2cblm_pkg::OP_WRITE) begin
                    pins_next.shift = tx_byte;
                end
                if (cmd_op == i2cblm_pkg::OP_READ) begin
                    ack_next = send_ack;
                end
                pins_next = i2cblm_pkg::enter_phase(cmd_op, '0, 2'd0, sda_in, ack_next,
                                                    pins_next);
            end else begin
                dropped = 1'b1;
            end
        end

        m_tdata_next = {3'b000, dropped, rx_hold_next, rx_valid,
                        (op_next != i2cblm_pkg::OP_IDLE),
                        pins_next.in_mode | pins_next.sda, pins_next.scl};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cblm_pkg::TICKS_W'(5);
            div_reg         <= '0;
            phase_reg       <= '0;
            sub_reg         <= '0;
            op_reg          <= i2cblm_pkg::OP_IDLE;
            pins_reg        <= i2cblm_pkg::PINS_RESET;
            ack_reg         <= 1'b0;
            rx_hold_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                phase_ticks_reg <= cfg_data;
            end
            if (s_accept) begin
                div_reg     <= div_next;
                phase_reg   <= phase_next;
                sub_reg     <= sub_next;
                op_reg      <= op_next;
                pins_reg    <= pins_next;
                ack_reg     <= ack_next;
                rx_hold_reg <= rx_hold_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_idle_clears_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg == i2cblm_pkg::OP_IDLE) |-> (phase_reg == '0 && div_reg == '0))
        else $error("idle sequencer holds a nonzero phase or divider");

    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < i2cblm_pkg::PHASE_W'(i2cblm_pkg::WRITE_PHASES))
        else $error("phase index out of range");

    a_sub_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg != 2'd3)
        else $error("bit slot position out of range");

    a_busy_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tdata_reg[2] == (op_reg != i2cblm_pkg::OP_IDLE)))
        else $error("reported busy flag disagrees with sequencer state");

endmodule
